@@ rtl/shbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shbd_pkg
// Shared constants, types and helpers of the 2x separable downscaler.
// ----------------------------------------------------------------------------
package shbd_pkg;

    localparam int NUM_TAPS      = 6;
    localparam int STORE_ROWS    = 11;
    localparam int WIN_TAPS      = 12;
    localparam int NUM_LANES     = 3;
    localparam int IN_BITS       = 16;
    localparam int COEF_BITS     = 10;
    localparam int DIM_BITS      = 11;
    localparam int DIM_EXT_BITS  = 14;
    localparam int ROW_BITS      = 10;
    localparam int POS_BITS      = 9;
    localparam int SLOT_BITS     = 4;
    localparam int DIST_BITS     = 4;
    localparam int LANE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int MIN_DIM       = 12;
    localparam int MAX_HEIGHT    = 1024;
    localparam int CENTER_LAG    = 6;
    localparam int OUT_DATA_BITS = 40;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - IN_BITS - 2 * POS_BITS;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_ROUND_SHIFT = 8;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_CENTER  = 3'd0,
        REG_COEF_SECOND  = 3'd1,
        REG_COEF_THIRD   = 3'd2,
        REG_COEF_FOURTH  = 3'd3,
        REG_COEF_FIFTH   = 3'd4,
        REG_COEF_OUTER   = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } reg_index_t;

    localparam coef_t COEF_RESET [NUM_TAPS] = '{
        10'sd86, 10'sd46, 10'sd4, -10'sd8, -10'sd4, 10'sd4
    };
    localparam logic [DIM_BITS-1:0] DIM_RESET = 11'd1024;

    // what one input sample asks of the filters
    typedef struct packed {
        logic                v_any;
        logic                v_three;
        logic                h_any;
        logic                h_three;
        logic [POS_BITS-1:0] row_base;
    } job_t;

    // distance from the newest sample to the older sample of the center pair
    function automatic logic [DIST_BITS-1:0] lane_offset(input logic three,
                                                         input logic [LANE_BITS-1:0] lane);
        logic [DIST_BITS-1:0] e;
        if (three) begin
            e = DIST_BITS'(CENTER_LAG - 1) - DIST_BITS'({lane, 1'b0});
        end else begin
            e = DIST_BITS'(CENTER_LAG);
        end
        return e;
    endfunction

    function automatic logic [DIST_BITS-1:0] far_dist(input logic [DIST_BITS-1:0] e,
                                                      input int k);
        return e + DIST_BITS'(k);
    endfunction

    // newer sample of a pair, clamped at the newest one
    function automatic logic [DIST_BITS-1:0] near_dist(input logic [DIST_BITS-1:0] e,
                                                       input int k);
        logic [DIST_BITS-1:0] d;
        if (e > DIST_BITS'(k)) begin
            d = e - DIST_BITS'(k) - DIST_BITS'(1);
        end else begin
            d = '0;
        end
        return d;
    endfunction

    // bank holding the row d rows above the row in slot, modulo the store depth
    function automatic logic [SLOT_BITS-1:0] bank_of(input logic [SLOT_BITS-1:0] slot,
                                                     input logic [DIST_BITS-1:0] d);
        logic [SLOT_BITS-1:0] b;
        if (slot >= d) begin
            b = slot - d;
        end else begin
            b = slot + SLOT_BITS'(STORE_ROWS) - d;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/shbd_line_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shbd_line_store
// Eleven row banks; all banks are read at one column, one bank is written.
// ----------------------------------------------------------------------------
module shbd_line_store #(
    parameter int MAX_WIDTH = shbd_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [shbd_pkg::SLOT_BITS-1:0]         wr_bank,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
    input  wire logic signed [shbd_pkg::IN_BITS-1:0]    wr_data,
    input  wire logic                                   re,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
    output logic signed [shbd_pkg::IN_BITS-1:0]         rd_data [shbd_pkg::STORE_ROWS]
);
    import shbd_pkg::*;

    for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
        logic signed [IN_BITS-1:0] mem [MAX_WIDTH];

        always_ff @(posedge aclk) begin
            if (we && wr_bank == SLOT_BITS'(b)) begin
                mem[wr_addr] <= wr_data;
            end
        end

        always_ff @(posedge aclk) begin
            if (re) begin
                rd_data[b] <= mem[rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/shbd_vfilt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shbd_vfilt
// Vertical 12-tap filter, three lanes for the three output rows of the
// bottom edge; products registered, sums and rounding after the register.
// ----------------------------------------------------------------------------
module shbd_vfilt #(
    parameter int SAMPLE_BITS = shbd_pkg::DEF_SAMPLE_BITS,
    parameter int ROUND_SHIFT = shbd_pkg::DEF_ROUND_SHIFT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [shbd_pkg::IN_BITS-1:0]    rd_data [shbd_pkg::STORE_ROWS],
    input  wire logic signed [shbd_pkg::IN_BITS-1:0]    cur,
    input  wire logic [shbd_pkg::ROW_BITS-1:0]          row,
    input  wire logic [shbd_pkg::SLOT_BITS-1:0]         slot,
    input  wire logic                                   three,
    input  wire shbd_pkg::coef_t                        coef [shbd_pkg::NUM_TAPS],
    output logic signed [SAMPLE_BITS-1:0]               vres [shbd_pkg::NUM_LANES]
);
    import shbd_pkg::*;

    localparam int PROD_BITS = IN_BITS + 1 + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (ROUND_SHIFT - 1);

    logic signed [IN_BITS-1:0]   rv [WIN_TAPS];
    logic signed [PROD_BITS-1:0] prod_next [NUM_LANES][NUM_TAPS];
    logic signed [PROD_BITS-1:0] prod_reg  [NUM_LANES][NUM_TAPS];

    // rows above the top of the picture repeat the first row
    always_comb begin
        logic [DIST_BITS-1:0] dd;
        for (int d = 0; d < WIN_TAPS; d++) begin
            dd = (row < ROW_BITS'(d)) ? DIST_BITS'(row) : DIST_BITS'(d);
            if (dd == '0) begin
                rv[d] = cur;
            end else begin
                rv[d] = rd_data[bank_of(slot, dd)];
            end
        end
    end

    always_comb begin
        logic [DIST_BITS-1:0] e;
        for (int j = 0; j < NUM_LANES; j++) begin
            e = lane_offset(three, LANE_BITS'(j));
            for (int k = 0; k < NUM_TAPS; k++) begin
                prod_next[j][k] = (PROD_BITS'(rv[far_dist(e, k)]) +
                                   PROD_BITS'(rv[near_dist(e, k)])) * PROD_BITS'(coef[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        logic signed [ACC_BITS-1:0] acc;
        for (int j = 0; j < NUM_LANES; j++) begin
            acc = ROUND_HALF;
            for (int k = 0; k < NUM_TAPS; k++) begin
                acc = acc + ACC_BITS'(prod_reg[j][k]);
            end
            acc = acc >>> ROUND_SHIFT;
            vres[j] = acc[SAMPLE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/shbd_hfilt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shbd_hfilt
// Horizontal windows of vertical results, result sequencer, horizontal
// filter with registered products, and the output register.
// ----------------------------------------------------------------------------
module shbd_hfilt #(
    parameter int MAX_WIDTH   = shbd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = shbd_pkg::DEF_SAMPLE_BITS,
    parameter int ROUND_SHIFT = shbd_pkg::DEF_ROUND_SHIFT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   load,
    input  wire shbd_pkg::job_t                         job,
    input  wire logic signed [SAMPLE_BITS-1:0]          vres [shbd_pkg::NUM_LANES],
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           col,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           col_base,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]           col_done,
    input  wire logic [shbd_pkg::POS_BITS-1:0]          row_done,
    input  wire shbd_pkg::coef_t                        coef [shbd_pkg::NUM_TAPS],
    output logic                                        seq_ready,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [shbd_pkg::OUT_DATA_BITS-1:0]          m_tdata,
    output logic                                        m_tlast,
    output logic                                        m_tuser
);
    import shbd_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int PROD_BITS = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (ROUND_SHIFT - 1);
    localparam logic [LANE_BITS-1:0] LAST_LANE = LANE_BITS'(NUM_LANES - 1);

    // windows: tap t holds the vertical result of column col - t
    logic signed [SAMPLE_BITS-1:0] win_reg [NUM_LANES][WIN_TAPS];

    always_ff @(posedge aclk) begin
        if (load && job.v_any) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                if (j == 0 || job.v_three) begin
                    for (int t = 0; t < WIN_TAPS; t++) begin
                        // first column fills the window, which clamps the left edge
                        if (col == '0 || t == 0) begin
                            win_reg[j][t] <= vres[j];
                        end else begin
                            win_reg[j][t] <= win_reg[j][t-1];
                        end
                    end
                end
            end
        end
    end

    // sequencer over the results of one input sample
    logic                 seq_v_reg, seq_v_next;
    logic [LANE_BITS-1:0] lane_reg, lane_next;
    logic [LANE_BITS-1:0] pos_reg, pos_next;
    job_t                 sjob_reg, sjob_next;
    logic [COL_BITS-1:0]  scol_reg, scol_next;
    logic [LANE_BITS-1:0] lane_max, pos_max;
    logic                 seq_last, emit, start;
    logic                 h1_ready, out_ready;

    logic                 h1_v_reg;
    logic signed [PROD_BITS-1:0] h1_prod_reg [NUM_TAPS];
    logic signed [PROD_BITS-1:0] h1_prod_next [NUM_TAPS];
    logic [POS_BITS-1:0]  h1_row_reg;
    logic [COL_BITS-1:0]  h1_col_reg;
    logic                 h1_last_reg, h1_done_reg;
    logic [POS_BITS-1:0]  emit_row;
    logic [COL_BITS-1:0]  emit_col;

    logic                 out_v_reg;
    logic signed [SAMPLE_BITS-1:0] out_res;
    logic [IN_BITS-1:0]   out_sample_reg;
    logic [POS_BITS-1:0]  out_row_reg;
    logic [POS_BITS-1:0]  out_col_reg;
    logic                 out_last_reg, out_done_reg;

    assign lane_max  = sjob_reg.v_three ? LAST_LANE : '0;
    assign pos_max   = sjob_reg.h_three ? LAST_LANE : '0;
    assign seq_last  = (lane_reg == lane_max) && (pos_reg == pos_max);
    assign out_ready = !out_v_reg || m_tready;
    assign h1_ready  = !h1_v_reg || out_ready;
    assign emit      = seq_v_reg && h1_ready;
    assign seq_ready = !seq_v_reg || (emit && seq_last);
    assign start     = load && job.v_any && job.h_any;

    always_comb begin
        seq_v_next = seq_v_reg;
        lane_next  = lane_reg;
        pos_next   = pos_reg;
        sjob_next  = sjob_reg;
        scol_next  = scol_reg;
        if (emit) begin
            if (seq_last) begin
                seq_v_next = 1'b0;
            end else if (pos_reg == pos_max) begin
                pos_next  = '0;
                lane_next = lane_reg + LANE_BITS'(1);
            end else begin
                pos_next = pos_reg + LANE_BITS'(1);
            end
        end
        if (start) begin
            seq_v_next = 1'b1;
            lane_next  = '0;
            pos_next   = '0;
            sjob_next  = job;
            scol_next  = col_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_v_reg <= 1'b0;
        end else begin
            seq_v_reg <= seq_v_next;
        end
        lane_reg <= lane_next;
        pos_reg  <= pos_next;
        sjob_reg <= sjob_next;
        scol_reg <= scol_next;
    end

    // horizontal products for the current result
    always_comb begin
        logic [DIST_BITS-1:0] e;
        e = lane_offset(sjob_reg.h_three, pos_reg);
        for (int k = 0; k < NUM_TAPS; k++) begin
            h1_prod_next[k] = (PROD_BITS'(win_reg[lane_reg][far_dist(e, k)]) +
                               PROD_BITS'(win_reg[lane_reg][near_dist(e, k)])) *
                              PROD_BITS'(coef[k]);
        end
    end

    assign emit_row = sjob_reg.row_base + POS_BITS'(lane_reg);
    assign emit_col = scol_reg + COL_BITS'(pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_v_reg <= 1'b0;
        end else if (h1_ready) begin
            h1_v_reg <= emit;
        end
        if (emit) begin
            h1_prod_reg <= h1_prod_next;
            h1_row_reg  <= emit_row;
            h1_col_reg  <= emit_col;
            h1_last_reg <= seq_last;
            h1_done_reg <= (emit_row == row_done) && (emit_col == col_done);
        end
    end

    always_comb begin
        logic signed [ACC_BITS-1:0] acc;
        acc = ROUND_HALF;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc = acc + ACC_BITS'(h1_prod_reg[k]);
        end
        acc     = acc >>> ROUND_SHIFT;
        out_res = acc[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_ready) begin
            out_v_reg <= h1_v_reg;
        end
        if (h1_v_reg && out_ready) begin
            out_sample_reg <= IN_BITS'(out_res);
            out_row_reg    <= h1_row_reg;
            out_col_reg    <= POS_BITS'(h1_col_reg);
            out_last_reg   <= h1_last_reg;
            out_done_reg   <= h1_done_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_col_reg, out_row_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule
`default_nettype wire

@@ rtl/separable_halfband_downscaler_2x.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// separable_halfband_downscaler_2x
// Halves a raster picture in both directions with separable 12-tap filters.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless held. A sample that completes output
// samples holds the input while its results are sent, since the output port
// sends one result per cycle while m_tready is high: one on even rows and
// columns from index 6 on, three on the last column or last row, nine on the
// last sample of a frame. The line store is eleven simple dual-port banks of
// MAX_WIDTH samples, read all at one column; it needs no clearing pass after
// reset. Width and height in use are clamped to [12, MAX_WIDTH] and [12, 1024]
// and made even; writing either restarts the frame. The user must write
// registers only while the block is idle; the block does not enforce it.
module separable_halfband_downscaler_2x #(
    parameter int MAX_WIDTH   = shbd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = shbd_pkg::DEF_SAMPLE_BITS,
    parameter int ROUND_SHIFT = shbd_pkg::DEF_ROUND_SHIFT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // sample_in
    input  wire logic [shbd_pkg::IN_BITS-1:0]           s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // sample_out, out_row, out_col, zero pad
    output logic [shbd_pkg::OUT_DATA_BITS-1:0]          m_tdata,
    output logic                                        m_tlast,
    // frame_done
    output logic                                        m_tuser,
    input  wire logic                                   cfg_we,
    input  wire logic [shbd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [shbd_pkg::DIM_BITS-1:0]          cfg_wdata
);
    import shbd_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = COL_BITS + 1;

    // configuration
    coef_t               coef_reg [NUM_TAPS];
    coef_t               coef_next [NUM_TAPS];
    logic [DIM_BITS-1:0] fw_reg, fw_next;
    logic [DIM_BITS-1:0] fh_reg, fh_next;
    logic                dim_write;

    always_comb begin
        coef_next = coef_reg;
        fw_next   = fw_reg;
        fh_next   = fh_reg;
        dim_write = 1'b0;
        if (cfg_we) begin
            unique case (reg_index_t'(cfg_index)) inside
                [REG_COEF_CENTER:REG_COEF_OUTER]: begin
                    coef_next[cfg_index] = coef_t'(cfg_wdata[COEF_BITS-1:0]);
                end
                REG_FRAME_WIDTH: begin
                    fw_next   = cfg_wdata;
                    dim_write = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    fh_next   = cfg_wdata;
                    dim_write = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
            fw_reg   <= DIM_RESET;
            fh_reg   <= DIM_RESET;
        end else begin
            coef_reg <= coef_next;
            fw_reg   <= fw_next;
            fh_reg   <= fh_next;
        end
    end

    // dimensions in use
    logic [DIM_EXT_BITS-1:0] w_ext, h_ext;
    logic [WID_BITS-1:0]     w_use;
    logic [DIM_BITS-1:0]     h_use;
    logic [COL_BITS-1:0]     col_done;
    logic [ROW_BITS-1:0]     half_h;

    always_comb begin
        w_ext = DIM_EXT_BITS'(fw_reg);
        if (w_ext < DIM_EXT_BITS'(MIN_DIM)) w_ext = DIM_EXT_BITS'(MIN_DIM);
        if (w_ext > DIM_EXT_BITS'(MAX_WIDTH)) w_ext = DIM_EXT_BITS'(MAX_WIDTH);
        w_ext[0] = 1'b0;
        if (w_ext < DIM_EXT_BITS'(MIN_DIM)) w_ext = DIM_EXT_BITS'(MIN_DIM);
        h_ext = DIM_EXT_BITS'(fh_reg);
        if (h_ext < DIM_EXT_BITS'(MIN_DIM)) h_ext = DIM_EXT_BITS'(MIN_DIM);
        if (h_ext > DIM_EXT_BITS'(MAX_HEIGHT)) h_ext = DIM_EXT_BITS'(MAX_HEIGHT);
        h_ext[0] = 1'b0;
    end

    assign w_use    = WID_BITS'(w_ext);
    assign h_use    = DIM_BITS'(h_ext);
    assign col_done = w_use[WID_BITS-1:1] - COL_BITS'(1);
    assign half_h   = h_use[DIM_BITS-1:1] - ROW_BITS'(1);

    // input position
    logic [COL_BITS-1:0]  in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]  in_row_reg, in_row_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic                 s_accept, col_last, row_last;
    logic [DIM_BITS-1:0]  rb_full;
    logic [WID_BITS-1:0]  cb_full;
    job_t                 in_job;
    logic [COL_BITS-1:0]  in_col_base;

    assign s_accept = s_tvalid && s_tready;
    assign col_last = ({1'b0, in_col_reg} == w_use - WID_BITS'(1));
    assign row_last = ({1'b0, in_row_reg} == h_use - DIM_BITS'(1));
    assign rb_full  = row_last ? h_use - DIM_BITS'(CENTER_LAG)
                               : {1'b0, in_row_reg} - DIM_BITS'(CENTER_LAG);
    assign cb_full  = col_last ? w_use - WID_BITS'(CENTER_LAG)
                               : {1'b0, in_col_reg} - WID_BITS'(CENTER_LAG);

    always_comb begin
        in_job.v_three  = row_last;
        in_job.v_any    = row_last ||
                          (!in_row_reg[0] && in_row_reg >= ROW_BITS'(CENTER_LAG));
        in_job.h_three  = col_last;
        in_job.h_any    = col_last ||
                          (!in_col_reg[0] && in_col_reg >= COL_BITS'(CENTER_LAG));
        in_job.row_base = rb_full[ROW_BITS-1:1];
        in_col_base     = cb_full[WID_BITS-1:1];
    end

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        slot_next   = slot_reg;
        if (s_accept) begin
            if (col_last) begin
                in_col_next = '0;
                if (row_last) begin
                    in_row_next = '0;
                    slot_next   = '0;
                end else begin
                    in_row_next = in_row_reg + ROW_BITS'(1);
                    slot_next   = (slot_reg == SLOT_BITS'(STORE_ROWS - 1)) ? '0
                                : slot_reg + SLOT_BITS'(1);
                end
            end else begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
        end
        if (dim_write) begin
            in_col_next = '0;
            in_row_next = '0;
            slot_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            slot_reg   <= '0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            slot_reg   <= slot_next;
        end
    end

    // pipeline: input register with line store read, then vertical products
    logic                        v1_v_reg, v2_v_reg;
    logic                        v1_adv, v2_adv, v2_ready, seq_ready;
    logic signed [IN_BITS-1:0]   v1_sample_reg;
    logic [ROW_BITS-1:0]         v1_row_reg;
    logic [COL_BITS-1:0]         v1_col_reg, v2_col_reg;
    logic [COL_BITS-1:0]         v1_cbase_reg, v2_cbase_reg;
    logic [SLOT_BITS-1:0]        v1_slot_reg;
    job_t                        v1_job_reg, v2_job_reg;
    logic signed [IN_BITS-1:0]   rd_data [STORE_ROWS];
    logic signed [SAMPLE_BITS-1:0] vres [NUM_LANES];

    assign v2_adv   = v2_v_reg && seq_ready;
    assign v2_ready = !v2_v_reg || v2_adv;
    assign v1_adv   = v1_v_reg && v2_ready;
    assign s_tready = !v1_v_reg || v2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_v_reg <= 1'b0;
            v2_v_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                v1_v_reg <= 1'b1;
            end else if (v1_adv) begin
                v1_v_reg <= 1'b0;
            end
            if (v1_adv) begin
                v2_v_reg <= 1'b1;
            end else if (v2_adv) begin
                v2_v_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            v1_sample_reg <= s_tdata;
            v1_row_reg    <= in_row_reg;
            v1_col_reg    <= in_col_reg;
            v1_cbase_reg  <= in_col_base;
            v1_slot_reg   <= slot_reg;
            v1_job_reg    <= in_job;
        end
        if (v1_adv) begin
            v2_col_reg   <= v1_col_reg;
            v2_cbase_reg <= v1_cbase_reg;
            v2_job_reg   <= v1_job_reg;
        end
    end

    shbd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .we      (v1_adv),
        .wr_bank (v1_slot_reg),
        .wr_addr (v1_col_reg),
        .wr_data (v1_sample_reg),
        .re      (s_accept),
        .rd_addr (in_col_reg),
        .rd_data (rd_data)
    );

    shbd_vfilt #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROUND_SHIFT (ROUND_SHIFT)
    ) u_vfilt (
        .aclk    (aclk),
        .en      (v1_adv),
        .rd_data (rd_data),
        .cur     (v1_sample_reg),
        .row     (v1_row_reg),
        .slot    (v1_slot_reg),
        .three   (v1_job_reg.v_three),
        .coef    (coef_reg),
        .vres    (vres)
    );

    shbd_hfilt #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROUND_SHIFT (ROUND_SHIFT)
    ) u_hfilt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (v2_adv),
        .job       (v2_job_reg),
        .vres      (vres),
        .col       (v2_col_reg),
        .col_base  (v2_cbase_reg),
        .col_done  (col_done),
        .row_done  (half_h[POS_BITS-1:0]),
        .coef      (coef_reg),
        .seq_ready (seq_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // input position stays inside the picture in use
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, in_col_reg} < w_use)
        else $error("input column beyond frame width");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_BITS'(STORE_ROWS - 1))
        else $error("line store slot out of range");

    // the frame's final result closes the burst of its sample
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end result not marked last");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && col_last && row_last |=> in_col_reg == '0 && in_row_reg == '0)
        else $error("position did not wrap at frame end");

endmodule
`default_nettype wire

@@ tb/separable_halfband_downscaler_2x_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// separable_halfband_downscaler_2x_tb
// Self-checking bench for the 2x separable 12-tap downscaler.
// ----------------------------------------------------------------------------
// Streams frames of samples through the block and predicts every output
// sample from its own model of the line store, the horizontal windows and
// the filter arithmetic. Covers sample and weight extremes, clamped and odd
// dimensions, and a frame restarted part way. Both stream sides idle at
// random.
module separable_halfband_downscaler_2x_tb;
    import shbd_pkg::*;

    typedef struct packed {
        logic [15:0]         sample;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
        logic                done;
    } pixel_out_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [DIM_BITS-1:0]      cfg_wdata = '0;

    separable_halfband_downscaler_2x dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic signed [15:0]          lines [STORE_ROWS][DEF_MAX_WIDTH];
    logic signed [15:0]          hwin [NUM_LANES][WIN_TAPS];
    logic signed [COEF_BITS-1:0] weights [NUM_TAPS];
    logic [DIM_BITS-1:0]         width_reg, height_reg;
    int                          pos_col, pos_row;

    pixel_out_t pending_pixels [$];
    int         error_count = 0;
    int         result_count = 0;
    int         sample_count = 0;
    int         ready_hold = 0;

    function automatic int dim_in_use(int raw, int maxv);
        int d;
        d = raw;
        if (d < MIN_DIM) d = MIN_DIM;
        if (d > maxv) d = maxv;
        d = d & ~1;
        if (d < MIN_DIM) d = MIN_DIM;
        return d;
    endfunction

    function automatic logic [15:0] round_narrow(longint acc);
        longint s;
        s = (acc + 128) >>> DEF_ROUND_SHIFT;
        return s[15:0];
    endfunction

    function automatic longint clamp_idx(longint k, longint hi);
        return k < 0 ? 0 : (k > hi ? hi : k);
    endfunction

    function automatic longint tap_row(longint k, int h, int r, int c, logic signed [15:0] cur);
        longint idx;
        idx = clamp_idx(k, h - 1);
        if (idx == r) return cur;
        return lines[idx % STORE_ROWS][c];
    endfunction

    // advances the model by one input sample and queues the pixels it finishes
    task automatic predict_sample(logic signed [15:0] cur);
        int w, h, nr, nc, rfirst, cfirst;
        longint y, x, acc, a, b;
        pixel_out_t p;
        w = dim_in_use(width_reg, DEF_MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        nr = 0; nc = 0; rfirst = 0; cfirst = 0;
        if (pos_row == h - 1) begin
            nr = 3; rfirst = (h - 6) / 2;
        end else if (pos_row % 2 == 0 && pos_row >= 6) begin
            nr = 1; rfirst = (pos_row - 6) / 2;
        end
        if (pos_col == w - 1) begin
            nc = 3; cfirst = (w - 6) / 2;
        end else if (pos_col % 2 == 0 && pos_col >= 6) begin
            nc = 1; cfirst = (pos_col - 6) / 2;
        end
        for (int j = 0; j < nr; j++) begin
            y = 2 * (rfirst + j);
            acc = 0;
            for (int k = 0; k < NUM_TAPS; k++)
                acc += (tap_row(y - k, h, pos_row, pos_col, cur) +
                        tap_row(y + 1 + k, h, pos_row, pos_col, cur)) * longint'(weights[k]);
            hwin[j][pos_col % WIN_TAPS] = round_narrow(acc);
        end
        lines[pos_row % STORE_ROWS][pos_col] = cur;
        for (int j = 0; j < nr; j++) begin
            for (int i = 0; i < nc; i++) begin
                x = 2 * (cfirst + i);
                acc = 0;
                for (int k = 0; k < NUM_TAPS; k++) begin
                    a = clamp_idx(x - k, w - 1);
                    b = clamp_idx(x + 1 + k, w - 1);
                    acc += (longint'(hwin[j][a % WIN_TAPS]) + longint'(hwin[j][b % WIN_TAPS]))
                           * longint'(weights[k]);
                end
                p.sample = round_narrow(acc);
                p.row    = POS_BITS'(rfirst + j);
                p.col    = POS_BITS'(cfirst + i);
                p.last   = (j + 1 == nr) && (i + 1 == nc);
                p.done   = (rfirst + j == h / 2 - 1) && (cfirst + i == w / 2 - 1);
                pending_pixels.push_back(p);
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: mostly short stalls, now and then a long one
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            ready_hold = $urandom_range(8, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
        end
    end

    // result checker
    always @(posedge aclk) begin
        pixel_out_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel data=%h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end else begin
                exp_p = pending_pixels.pop_front();
                if (m_tdata[15:0] !== exp_p.sample) begin
                    $display("%0t: sample_out expected %h actual %h", $time, exp_p.sample,
                             m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[24:16] !== exp_p.row) begin
                    $display("%0t: out_row expected %0d actual %0d", $time, exp_p.row,
                             m_tdata[24:16]);
                    error_count++;
                end
                if (m_tdata[33:25] !== exp_p.col) begin
                    $display("%0t: out_col expected %0d actual %0d", $time, exp_p.col,
                             m_tdata[33:25]);
                    error_count++;
                end
                if (m_tdata[OUT_DATA_BITS-1:34] !== '0) begin
                    $display("%0t: pad expected 0 actual %h", $time, m_tdata[OUT_DATA_BITS-1:34]);
                    error_count++;
                end
                if (m_tlast !== exp_p.last) begin
                    $display("%0t: run_last expected %b actual %b", $time, exp_p.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== exp_p.done) begin
                    $display("%0t: frame_done expected %b actual %b", $time, exp_p.done, m_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic send_sample(logic [15:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        predict_sample(v);
        sample_count++;
        gap = random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [DIM_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx < REG_FRAME_WIDTH) begin
            weights[idx] = v[COEF_BITS-1:0];
        end else begin
            if (idx == REG_FRAME_WIDTH) width_reg = v;
            else height_reg = v;
            pos_col = 0;
            pos_row = 0;
        end
    endtask

    task automatic set_dims(int w, int h);
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(w));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(h));
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(int w, int h);
        int n;
        n = dim_in_use(w, DEF_MAX_WIDTH) * dim_in_use(h, MAX_HEIGHT);
        repeat (n) send_sample(random_sample());
        drain();
    endtask

    // smallest frame with sample extremes and the default weights
    task automatic test_extreme_samples();
        set_dims(12, 12);
        for (int i = 0; i < 144; i++) begin
            case (i % 4)
                0: send_sample(16'h7FFF);
                1: send_sample(16'h8000);
                2: send_sample(16'h0000);
                default: send_sample(16'hFFFF);
            endcase
        end
        drain();
    endtask

    // largest and smallest weights in turn, over the first output row
    task automatic test_weight_extremes();
        for (int k = 0; k < NUM_TAPS; k++)
            write_reg(reg_index_t'(k), (k % 2 == 0) ? 11'h1FF : 11'h200);
        set_dims(12, 12);
        repeat (84) send_sample(random_sample());
        drain();
    endtask

    // odd and too small dimensions are clamped
    task automatic test_dimension_clamping();
        set_dims(13, 11);
        send_frame(13, 11);
    endtask

    // a dimension write in the middle of a frame starts a new frame
    task automatic test_frame_restart();
        set_dims(14, 12);
        repeat (20) send_sample(random_sample());
        drain();
        write_reg(REG_FRAME_WIDTH, 11'd12);
        repeat (84) send_sample(random_sample());
        drain();
    endtask

    initial begin
        for (int k = 0; k < NUM_TAPS; k++) weights[k] = COEF_RESET[k];
        width_reg  = DIM_RESET;
        height_reg = DIM_RESET;
        pos_col = 0;
        pos_row = 0;
        foreach (hwin[j, i]) hwin[j][i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_samples();
        test_weight_extremes();
        test_dimension_clamping();
        test_frame_restart();
        drain();
        $display("Sent %0d samples and checked %0d output pixels", sample_count, result_count);
        $display("over sample and weight extremes, clamped sizes and a restarted frame");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
